[hw/rtl/assert_macros.svh]
// assertion macros included by the spline kernel
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SQK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define SQK_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/sqk_pkg.sv]
// types and constants of the quartic spline kernel
package sqk_pkg;

  localparam int unsigned SQ_IN_W   = 40;
  localparam int unsigned SQ_ROOT_W = 20;
  localparam int unsigned SQ_REM_W  = 23;

  localparam int unsigned DV_NUM_W = 56;
  localparam int unsigned DV_DEN_W = 18;

  localparam int unsigned T_W = 18;

  localparam logic [SQ_ROOT_W-1:0] FX_HALF = 20'd32768;
  localparam logic [SQ_ROOT_W-1:0] FX_1P5  = 20'd98304;
  localparam logic [SQ_ROOT_W-1:0] FX_2P5  = 20'd163840;

  localparam logic [1:0] CFG_VALUE_SCALE    = 2'd0;
  localparam logic [1:0] CFG_GRADIENT_SCALE = 2'd1;

  localparam logic signed [79:0] G_MAX = 80'sd2147483647;
  localparam logic signed [79:0] G_MIN = -80'sd2147483648;

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } sqk_vec_t;

  typedef struct packed {
    logic [31:0] weight;
    logic        neg;
    logic        gzero;
    sqk_vec_t    vec;
  } sqk_div_side_t;

endpackage

[hw/rtl/sqk_isqrt.sv]
// pipelined integer square root, one root bit per stage
module sqk_isqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [sqk_pkg::SQ_IN_W-1:0]     rad_i,
  input  sqk_pkg::sqk_vec_t               side_i,
  output logic                            valid_o,
  output logic [sqk_pkg::SQ_ROOT_W-1:0]   root_o,
  output sqk_pkg::sqk_vec_t               side_o
);
  import sqk_pkg::*;

  logic                 v_q [SQ_ROOT_W];
  logic [SQ_IN_W-1:0]   n_q [SQ_ROOT_W];
  logic [SQ_REM_W-1:0]  r_q [SQ_ROOT_W];
  logic [SQ_ROOT_W-1:0] t_q [SQ_ROOT_W];
  sqk_vec_t             e_q [SQ_ROOT_W];

  for (genvar i = 0; i < SQ_ROOT_W; i++) begin : g_stg
    logic                 v_s;
    logic [SQ_IN_W-1:0]   n_s;
    logic [SQ_REM_W-1:0]  r_s;
    logic [SQ_ROOT_W-1:0] t_s;
    sqk_vec_t             e_s;
    logic [SQ_REM_W-1:0]  r2;
    logic [SQ_REM_W-1:0]  trial;
    logic                 ge;

    if (i == 0) begin : g_first
      assign v_s = valid_i;
      assign n_s = rad_i;
      assign r_s = '0;
      assign t_s = '0;
      assign e_s = side_i;
    end else begin : g_next
      assign v_s = v_q[i-1];
      assign n_s = n_q[i-1];
      assign r_s = r_q[i-1];
      assign t_s = t_q[i-1];
      assign e_s = e_q[i-1];
    end

    assign r2    = {r_s[SQ_REM_W-3:0], n_s[SQ_IN_W-1 -: 2]};
    assign trial = {1'b0, t_s, 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[i] <= {n_s[SQ_IN_W-3:0], 2'b00};
        r_q[i] <= ge ? (r2 - trial) : r2;
        t_q[i] <= {t_s[SQ_ROOT_W-2:0], ge};
        e_q[i] <= e_s;
      end
    end
  end

  assign valid_o = v_q[SQ_ROOT_W-1];
  assign root_o  = t_q[SQ_ROOT_W-1];
  assign side_o  = e_q[SQ_ROOT_W-1];

endmodule

[hw/rtl/sqk_div.sv]
// pipelined restoring divider, one quotient bit per stage
module sqk_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [sqk_pkg::DV_NUM_W-1:0]   num_i,
  input  logic [sqk_pkg::DV_DEN_W-1:0]   den_i,
  input  sqk_pkg::sqk_div_side_t         side_i,
  output logic                           valid_o,
  output logic [sqk_pkg::DV_NUM_W-1:0]   quo_o,
  output sqk_pkg::sqk_div_side_t         side_o
);
  import sqk_pkg::*;

  logic                v_q [DV_NUM_W];
  logic [DV_NUM_W-1:0] n_q [DV_NUM_W];
  logic [DV_DEN_W-1:0] r_q [DV_NUM_W];
  logic [DV_DEN_W-1:0] d_q [DV_NUM_W];
  sqk_div_side_t       e_q [DV_NUM_W];

  for (genvar i = 0; i < DV_NUM_W; i++) begin : g_stg
    logic                v_s;
    logic [DV_NUM_W-1:0] n_s;
    logic [DV_DEN_W-1:0] r_s;
    logic [DV_DEN_W-1:0] d_s;
    sqk_div_side_t       e_s;
    logic [DV_DEN_W:0]   r2;
    logic [DV_DEN_W:0]   diff;
    logic                ge;

    if (i == 0) begin : g_first
      assign v_s = valid_i;
      assign n_s = num_i;
      assign r_s = '0;
      assign d_s = den_i;
      assign e_s = side_i;
    end else begin : g_next
      assign v_s = v_q[i-1];
      assign n_s = n_q[i-1];
      assign r_s = r_q[i-1];
      assign d_s = d_q[i-1];
      assign e_s = e_q[i-1];
    end

    assign r2   = {r_s, n_s[DV_NUM_W-1]};
    assign ge   = (r2 >= {1'b0, d_s});
    assign diff = r2 - {1'b0, d_s};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[i] <= {n_s[DV_NUM_W-2:0], ge};
        r_q[i] <= ge ? diff[DV_DEN_W-1:0] : r2[DV_DEN_W-1:0];
        d_q[i] <= d_s;
        e_q[i] <= e_s;
      end
    end
  end

  assign valid_o = v_q[DV_NUM_W-1];
  assign quo_o   = n_q[DV_NUM_W-1];
  assign side_o  = e_q[DV_NUM_W-1];

endmodule

[hw/rtl/sph_quartic_spline_kernel.sv]
// quartic spline kernel value and gradient, one particle pair per request
//
//  channel  dir  handshake                       payload
//  s_axis   in   s_axis_tvalid / s_axis_tready   dist_sq, dist_x, dist_y, dist_z
//  m_axis   out  m_axis_tvalid / m_axis_tready   weight, grad_x, grad_y, grad_z
//  cfg      in   cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
//
// one request per cycle while the output is not stalled; 20 square root stages,
// 5 polynomial and scaling stages, 56 divider stages, 2 gradient stages
// reset clears all valid bits and both scale registers
// a stall at the output freezes the whole pipeline in place
// cfg_ready_o is always high
module sph_quartic_spline_kernel (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,  // dist_sq, dist_x, dist_y, dist_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // weight, grad_x, grad_y, grad_z
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import sqk_pkg::*;

  logic        adv;
  logic [31:0] value_scale_q;
  logic signed [31:0] gradient_scale_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_scale_q    <= '0;
      gradient_scale_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_VALUE_SCALE:    value_scale_q    <= cfg_data_i;
        CFG_GRADIENT_SCALE: gradient_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // square root
  sqk_vec_t             in_vec;
  logic                 sq_v;
  logic [SQ_ROOT_W-1:0] sq_root;
  sqk_vec_t             sq_vec;

  assign in_vec.x = s_axis_tdata[55:24];
  assign in_vec.y = s_axis_tdata[87:56];
  assign in_vec.z = s_axis_tdata[119:88];

  sqk_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid),
    .rad_i   ({s_axis_tdata[23:0], 16'h0000}),
    .side_i  (in_vec),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_vec)
  );

  // stage 1: terms and squares
  logic           oor;
  logic [T_W-1:0] term [3];

  assign oor     = (sq_root >= FX_2P5);
  assign term[0] = oor ? '0 : T_W'(FX_2P5 - sq_root);
  assign term[1] = (sq_root < FX_1P5) ? T_W'(FX_1P5 - sq_root) : '0;
  assign term[2] = (sq_root < FX_HALF) ? T_W'(FX_HALF - sq_root) : '0;

  logic           p1_v_q;
  logic           p1_oor_q;
  logic           p1_gz_q;
  logic [T_W-1:0] p1_q_q;
  logic [T_W-1:0] p1_t_q  [3];
  logic [35:0]    p1_sq_q [3];
  sqk_vec_t       p1_vec_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_oor_q <= oor;
      p1_gz_q  <= oor || (sq_root == '0);
      p1_q_q   <= sq_root[T_W-1:0];
      p1_vec_q <= sq_vec;
      for (int i = 0; i < 3; i++) begin
        p1_t_q[i]  <= term[i];
        p1_sq_q[i] <= 36'(term[i]) * 36'(term[i]);
      end
    end
  end

  // stage 2: fourth and third powers
  logic [18:0] x2 [3];
  for (genvar i = 0; i < 3; i++) begin : g_x2
    assign x2[i] = 19'((p1_sq_q[i] + 36'd32768) >> 16);
  end

  logic           p2_v_q;
  logic           p2_gz_q;
  logic [T_W-1:0] p2_q_q;
  logic [37:0]    p2_p4_q [3];
  logic [36:0]    p2_p3_q [3];
  sqk_vec_t       p2_vec_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_gz_q  <= p1_gz_q;
      p2_q_q   <= p1_q_q;
      p2_vec_q <= p1_vec_q;
      for (int i = 0; i < 3; i++) begin
        p2_p4_q[i] <= 38'(x2[i]) * 38'(x2[i]);
        p2_p3_q[i] <= 37'(x2[i]) * 37'(p1_t_q[i]);
      end
    end
  end

  // stage 3: spline sums
  logic [21:0] x4 [3];
  logic [20:0] x3 [3];
  for (genvar i = 0; i < 3; i++) begin : g_rnd
    assign x4[i] = 22'((p2_p4_q[i] + 38'd32768) >> 16);
    assign x3[i] = 21'((p2_p3_q[i] + 37'd32768) >> 16);
  end

  logic signed [25:0] s_sum;
  logic signed [25:0] d_sum;

  assign s_sum = $signed(26'(x4[0]) - (26'(x4[1]) << 2) - 26'(x4[1])
               + (26'(x4[2]) << 3) + (26'(x4[2]) << 1));
  assign d_sum = $signed(26'(x3[0]) - (26'(x3[1]) << 2) - 26'(x3[1])
               + (26'(x3[2]) << 3) + (26'(x3[2]) << 1));

  logic               p3_v_q;
  logic               p3_gz_q;
  logic [T_W-1:0]     p3_q_q;
  logic signed [25:0] p3_s_q;
  logic signed [25:0] p3_d_q;
  sqk_vec_t           p3_vec_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_gz_q  <= p2_gz_q;
      p3_q_q   <= p2_q_q;
      p3_vec_q <= p2_vec_q;
      p3_s_q   <= s_sum;
      p3_d_q   <= d_sum;
    end
  end

  // stage 4: scale products
  logic [22:0] s_pos;
  assign s_pos = p3_s_q[25] ? '0 : p3_s_q[22:0];

  logic               p4_v_q;
  logic               p4_gz_q;
  logic [T_W-1:0]     p4_q_q;
  logic [54:0]        p4_w_q;
  logic signed [57:0] p4_g_q;
  sqk_vec_t           p4_vec_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p4_gz_q  <= p3_gz_q;
      p4_q_q   <= p3_q_q;
      p4_vec_q <= p3_vec_q;
      p4_w_q   <= 55'(value_scale_q) * 55'(s_pos);
      p4_g_q   <= gradient_scale_q * p3_d_q;
    end
  end

  // stage 5: weight rounding, dividend setup
  logic [38:0]         w_rnd;
  logic [57:0]         g_mag;
  logic [DV_NUM_W-1:0] p5_num_q;
  logic [DV_DEN_W-1:0] p5_den_q;
  logic                p5_v_q;
  sqk_div_side_t       p5_side_q;

  assign w_rnd = 39'((p4_w_q + 55'd32768) >> 16);
  assign g_mag = p4_g_q[57] ? 58'(-p4_g_q) : 58'(p4_g_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p5_num_q         <= DV_NUM_W'(g_mag) + DV_NUM_W'(p4_q_q >> 1);
      p5_den_q         <= p4_gz_q ? DV_DEN_W'(1) : p4_q_q;
      p5_side_q.weight <= (w_rnd > 39'h00FFFFFFFF) ? 32'hFFFFFFFF : w_rnd[31:0];
      p5_side_q.neg    <= p4_g_q[57];
      p5_side_q.gzero  <= p4_gz_q;
      p5_side_q.vec    <= p4_vec_q;
    end
  end

  // divide by q
  logic                dv_v;
  logic [DV_NUM_W-1:0] dv_quo;
  sqk_div_side_t       dv_side;

  sqk_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (p5_v_q),
    .num_i   (p5_num_q),
    .den_i   (p5_den_q),
    .side_i  (p5_side_q),
    .valid_o (dv_v),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // stage 6: gradient partial products
  logic        f_sat;
  logic [46:0] f_mag;
  logic [31:0] comp [3];
  logic [31:0] c_mag [3];

  assign f_sat   = !dv_side.gzero && (|dv_quo[DV_NUM_W-1:47]);
  assign f_mag   = dv_side.gzero ? '0 : dv_quo[46:0];
  assign comp[0] = dv_side.vec.x;
  assign comp[1] = dv_side.vec.y;
  assign comp[2] = dv_side.vec.z;

  for (genvar i = 0; i < 3; i++) begin : g_cmag
    assign c_mag[i] = comp[i][31] ? (32'd0 - comp[i]) : comp[i];
  end

  logic        p6_v_q;
  logic        p6_gz_q;
  logic [31:0] p6_w_q;
  logic [55:0] p6_lo_q  [3];
  logic [54:0] p6_hi_q  [3];
  logic        p6_sat_q [3];
  logic        p6_neg_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p6_gz_q <= dv_side.gzero;
      p6_w_q  <= dv_side.weight;
      for (int i = 0; i < 3; i++) begin
        p6_lo_q[i]  <= 56'(c_mag[i]) * 56'(f_mag[23:0]);
        p6_hi_q[i]  <= 55'(c_mag[i]) * 55'(f_mag[46:24]);
        p6_sat_q[i] <= f_sat && (|comp[i]);
        p6_neg_q[i] <= dv_side.neg ^ comp[i][31];
      end
    end
  end

  // stage 7: gradient rounding and saturation, output register
  logic [78:0]        prod [3];
  logic signed [79:0] pv   [3];
  logic signed [79:0] rv   [3];
  logic [31:0]        grad [3];

  for (genvar i = 0; i < 3; i++) begin : g_grad
    assign prod[i] = {p6_hi_q[i], 24'h000000} + 79'(p6_lo_q[i]);
    assign pv[i]   = p6_neg_q[i] ? -$signed({1'b0, prod[i]}) : $signed({1'b0, prod[i]});
    assign rv[i]   = (pv[i] + 80'sd32768) >>> 16;
    always_comb begin
      if (p6_sat_q[i]) begin
        grad[i] = p6_neg_q[i] ? G_MIN[31:0] : G_MAX[31:0];
      end else if (rv[i] > G_MAX) begin
        grad[i] = G_MAX[31:0];
      end else if (rv[i] < G_MIN) begin
        grad[i] = G_MIN[31:0];
      end else begin
        grad[i] = rv[i][31:0];
      end
    end
  end

  logic         out_v_q;
  logic [127:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {grad[2], grad[1], grad[0], p6_w_q};
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      p4_v_q  <= 1'b0;
      p5_v_q  <= 1'b0;
      p6_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      p1_v_q  <= sq_v;
      p2_v_q  <= p1_v_q;
      p3_v_q  <= p2_v_q;
      p4_v_q  <= p3_v_q;
      p5_v_q  <= p4_v_q;
      p6_v_q  <= dv_v;
      out_v_q <= p6_v_q;
    end
  end

  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

  `include "assert_macros.svh"

  `SQK_ASSERT_NXT(a_gzero_grad, adv && p6_v_q && p6_gz_q, m_axis_tdata[127:32] == '0)
  `SQK_ASSERT_NXT(a_oor_terms, adv && p1_v_q && p1_oor_q, p2_p4_q[0] == '0 && p2_p3_q[0] == '0)

endmodule
